### src/csshuf_pkg.sv
// ----------------------------------------------------------------------------
// csshuf_pkg: shared types and constants for the card sequence store
// Card store sizes, command codes, status codes and the draw generator mask.
// ----------------------------------------------------------------------------
package csshuf_pkg;

    localparam int CAPACITY   = 128;
    localparam int CARD_BITS  = 8;
    localparam int ADDR_BITS  = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_PUSH    = 2'd0;
    localparam mode_t MODE_REMOVE  = 2'd1;
    localparam mode_t MODE_SHUFFLE = 2'd2;
    localparam mode_t MODE_UNUSED  = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_BAD  = 2'd1;
    localparam status_t ST_FULL = 2'd2;

    localparam logic CFG_EMPTY_CARD = 1'b0;
    localparam logic CFG_SEED       = 1'b1;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [ADDR_BITS:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic                 done;
        logic [ADDR_BITS-1:0] rem;
    } mod_rsp_t;

endpackage

### src/csshuf_mod.sv
// ----------------------------------------------------------------------------
// csshuf_mod: bit-serial modulo unit
// Restoring remainder of a 32-bit value by a small divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module csshuf_mod (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  csshuf_pkg::mod_req_t req,
    output csshuf_pkg::mod_rsp_t rsp
);
    import csshuf_pkg::*;

    logic [31:0]        dvd_reg, dvd_next;
    logic [ADDR_BITS:0] div_reg, div_next;
    logic [ADDR_BITS:0] rem_reg, rem_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [ADDR_BITS+1:0] trial;

    always_comb begin
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[31]};
        if (req.start) begin
            dvd_next  = req.dividend;
            div_next  = req.divisor;
            rem_next  = '0;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[30:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next = (ADDR_BITS+1)'(trial - {1'b0, div_reg});
            end else begin
                rem_next = (ADDR_BITS+1)'(trial);
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg[ADDR_BITS-1:0];

endmodule

### src/card_sequence_store_with_shuffle.sv
// ----------------------------------------------------------------------------
// card_sequence_store_with_shuffle: ordered card store with shuffle
// Push at front, remove at position and Fisher-Yates shuffle over one RAM.
// ----------------------------------------------------------------------------
// Input transfers on s_axis carry one command each (push, remove, shuffle).
// Every command gives exactly one result transfer on m_axis with the removed
// card, a status code and the card count after the command.
// Cards live in a 128-entry RAM with one read and one write port. A push moves
// the entries up one by one from the top, a removal reads the entry at pos and
// moves the entries above it down, and a rejected command or a shuffle of fewer
// than two cards goes straight to the result. A shuffle runs per swap a draw step,
// a wait on the bit-serial modulo unit and three RAM steps (read, write i, write
// j), then a reversal pass that swaps pairs of entries moving inward.
// s_axis_tready is high only while idle; the next command is taken the cycle
// after the result is loaded. Configuration writes (index 0 empty card,
// index 1 seed) take effect at once.
// After reset the store is empty and the generator holds one; the RAM needs
// no clearing. The result sits in an output register; while the receiver
// stalls, one further command is taken and run, and its result then waits
// until the held transfer has gone.
// ----------------------------------------------------------------------------
module card_sequence_store_with_shuffle (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // mode[1:0], card_in[9:2], position[16:10]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // card_out[7:0], status[9:8], card_count[17:10]
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import csshuf_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_MVRD   = 11'b000_0000_0010,
        S_MVWR   = 11'b000_0000_0100,
        S_DRAW   = 11'b000_0000_1000,
        S_MODW   = 11'b000_0001_0000,
        S_SWRD   = 11'b000_0010_0000,
        S_SWWI   = 11'b000_0100_0000,
        S_SWWJ   = 11'b000_1000_0000,
        S_RVRD   = 11'b001_0000_0000,
        S_RVWR   = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CARD_BITS-1:0] mem [CAPACITY];
    logic [CARD_BITS-1:0] rdata_reg;
    logic                 we;
    logic [ADDR_BITS-1:0] waddr, raddr;
    logic [CARD_BITS-1:0] wdata;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [31:0]           lfsr_reg, lfsr_next;
    logic [7:0]            empty_reg, empty_next;
    mode_t                 mode_reg, mode_next;
    logic [CARD_BITS-1:0]  card_reg, card_next;
    logic [ADDR_BITS:0]    i_reg, i_next;
    logic [ADDR_BITS:0]    lo_reg, lo_next;
    logic [ADDR_BITS-1:0]  j_reg, j_next;
    logic [CARD_BITS-1:0]  t_reg, t_next;
    logic                  phase_reg, phase_next;
    logic [7:0]            res_card_reg, res_card_next;
    status_t               res_st_reg, res_st_next;
    logic [7:0]            out_card_reg, out_card_next;
    status_t               out_st_reg, out_st_next;
    logic [7:0]            out_count_reg, out_count_next;
    logic                  mvalid_reg, mvalid_next;

    mod_req_t mreq;
    mod_rsp_t mrsp;

    csshuf_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    logic [31:0] lfsr_step;
    assign lfsr_step = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_MASK) : (lfsr_reg >> 1);

    logic s_fire;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        lfsr_next      = lfsr_reg;
        empty_next     = empty_reg;
        mode_next      = mode_reg;
        card_next      = card_reg;
        i_next         = i_reg;
        lo_next        = lo_reg;
        j_next         = j_reg;
        t_next         = t_reg;
        phase_next     = phase_reg;
        res_card_next  = res_card_reg;
        res_st_next    = res_st_reg;
        out_card_next  = out_card_reg;
        out_st_next    = out_st_reg;
        out_count_next = out_count_reg;
        mvalid_next    = mvalid_reg;
        we             = 1'b0;
        waddr          = '0;
        raddr          = '0;
        wdata          = '0;
        mreq.start     = 1'b0;
        mreq.dividend  = lfsr_reg;
        mreq.divisor   = i_reg;

        if (m_axis_tvalid && m_axis_tready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    mode_next     = mode_t'(s_axis_tdata[1:0]);
                    card_next     = s_axis_tdata[2 +: CARD_BITS];
                    res_card_next = '0;
                    res_st_next   = ST_OK;
                    state_next    = S_OUT;
                    unique case (mode_t'(s_axis_tdata[1:0]))
                        MODE_PUSH: begin
                            if (count_reg >= COUNT_BITS'(CAPACITY)) begin
                                res_st_next = ST_FULL;
                            end else begin
                                // move entries [0,count) up; walk from the top
                                i_next     = (ADDR_BITS+1)'(count_reg);
                                lo_next    = '0;
                                state_next = S_MVRD;
                            end
                        end
                        MODE_REMOVE: begin
                            if ((COUNT_BITS+1)'(s_axis_tdata[16:10]) >=
                                (COUNT_BITS+1)'(count_reg)) begin
                                res_card_next = empty_reg;
                                res_st_next   = ST_BAD;
                            end else begin
                                i_next     = (ADDR_BITS+1)'(s_axis_tdata[16:10]);
                                phase_next = 1'b1;
                                state_next = S_MVRD;
                            end
                        end
                        MODE_SHUFFLE: begin
                            if (count_reg >= COUNT_BITS'(2)) begin
                                i_next     = (ADDR_BITS+1)'(count_reg - 1'b1);
                                state_next = S_DRAW;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MVRD: begin
                if (mode_reg == MODE_PUSH) begin
                    if (i_reg == lo_reg) begin
                        we         = 1'b1;
                        waddr      = '0;
                        wdata      = card_reg;
                        count_next = count_reg + 1'b1;
                        state_next = S_OUT;
                    end else begin
                        raddr      = ADDR_BITS'(i_reg - 1'b1);
                        state_next = S_MVWR;
                    end
                end else begin
                    if (phase_reg) begin
                        raddr = ADDR_BITS'(i_reg);
                        state_next = S_MVWR;
                    end else if ((i_reg + 1'b1) >= (ADDR_BITS+1)'(count_reg)) begin
                        count_next = count_reg - 1'b1;
                        state_next = S_OUT;
                    end else begin
                        raddr      = ADDR_BITS'(i_reg + 1'b1);
                        state_next = S_MVWR;
                    end
                end
            end
            S_MVWR: begin
                if (mode_reg == MODE_PUSH) begin
                    we     = 1'b1;
                    waddr  = ADDR_BITS'(i_reg);
                    wdata  = rdata_reg;
                    i_next = i_reg - 1'b1;
                end else if (phase_reg) begin
                    res_card_next = 8'(rdata_reg);
                    phase_next    = 1'b0;
                end else begin
                    we     = 1'b1;
                    waddr  = ADDR_BITS'(i_reg);
                    wdata  = rdata_reg;
                    i_next = i_reg + 1'b1;
                end
                state_next = S_MVRD;
            end
            S_DRAW: begin
                if (i_reg == '0) begin
                    i_next     = '0;
                    lo_next    = (ADDR_BITS+1)'(count_reg - 1'b1);
                    state_next = S_RVRD;
                end else begin
                    lfsr_next     = lfsr_step;
                    mreq.start    = 1'b1;
                    mreq.dividend = lfsr_step;
                    mreq.divisor  = i_reg + 1'b1;
                    state_next    = S_MODW;
                end
            end
            S_MODW: begin
                if (mrsp.done) begin
                    j_next     = mrsp.rem;
                    raddr      = ADDR_BITS'(i_reg);
                    state_next = S_SWRD;
                end
            end
            S_SWRD: begin
                t_next     = rdata_reg;
                raddr      = j_reg;
                state_next = S_SWWI;
            end
            S_SWWI: begin
                we         = 1'b1;
                waddr      = ADDR_BITS'(i_reg);
                wdata      = rdata_reg;
                state_next = S_SWWJ;
            end
            S_SWWJ: begin
                we         = 1'b1;
                waddr      = j_reg;
                wdata      = t_reg;
                i_next     = i_reg - 1'b1;
                state_next = S_DRAW;
            end
            S_RVRD: begin
                // swap i and lo moving inward
                if (i_reg >= lo_reg) begin
                    state_next = S_OUT;
                end else if (!phase_reg) begin
                    raddr      = ADDR_BITS'(i_reg);
                    phase_next = 1'b1;
                end else begin
                    // rdata holds entry i
                    t_next     = rdata_reg;
                    raddr      = ADDR_BITS'(lo_reg);
                    state_next = S_RVWR;
                end
            end
            S_RVWR: begin
                we = 1'b1;
                if (phase_reg) begin
                    // rdata holds entry lo
                    waddr      = ADDR_BITS'(i_reg);
                    wdata      = rdata_reg;
                    phase_next = 1'b0;
                end else begin
                    waddr      = ADDR_BITS'(lo_reg);
                    wdata      = t_reg;
                    i_next     = i_reg + 1'b1;
                    lo_next    = lo_reg - 1'b1;
                    state_next = S_RVRD;
                end
            end
            S_OUT: begin
                if (!mvalid_reg || (m_axis_tvalid && m_axis_tready)) begin
                    out_card_next  = res_card_reg;
                    out_st_next    = res_st_reg;
                    out_count_next = 8'(count_reg);
                    mvalid_next    = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_EMPTY_CARD: empty_next = cfg_wdata[7:0];
                CFG_SEED:       lfsr_next  = (cfg_wdata == '0) ? 32'd1 : cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            lfsr_reg   <= 32'd1;
            empty_reg  <= '0;
            mvalid_reg <= 1'b0;
            phase_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            lfsr_reg   <= lfsr_next;
            empty_reg  <= empty_next;
            mvalid_reg <= mvalid_next;
            phase_reg  <= phase_next;
        end
        mode_reg      <= mode_next;
        card_reg      <= card_next;
        i_reg         <= i_next;
        lo_reg        <= lo_next;
        j_reg         <= j_next;
        t_reg         <= t_next;
        res_card_reg  <= res_card_next;
        res_st_reg    <= res_st_next;
        out_card_reg  <= out_card_next;
        out_st_reg    <= out_st_next;
        out_count_reg <= out_count_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = {6'd0, out_count_reg, out_st_reg, out_card_reg};

endmodule

### dv/tb_card_sequence_store_with_shuffle.sv
// ----------------------------------------------------------------------------
// tb_card_sequence_store_with_shuffle: self-checking bench for the card store
// A directed command table runs first, then random command phases under
// changing empty-card and seed settings. Random bursts and gaps on the
// command side and stalls on the result side exercise both handshakes. Each
// result is checked field by field against an in-bench store and shuffle model.
// ----------------------------------------------------------------------------
module tb_card_sequence_store_with_shuffle;
    import csshuf_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = CFG_EMPTY_CARD;
    logic [31:0] cfg_wdata = '0;

    card_sequence_store_with_shuffle u_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    typedef struct packed {
        logic [7:0] card;
        status_t    status;
        logic [7:0] count;
    } outcome_t;

    typedef struct {
        mode_t      mode;
        logic [7:0] card;
        logic [6:0] pos;
        bit         typed;
        outcome_t   want;
    } cmd_row_t;

    // model state
    logic [CARD_BITS-1:0] deck [CAPACITY];
    int                   held;
    logic [31:0]          lfsr;
    logic [7:0]           empty_code;

    outcome_t pending_q[$];
    int       errors;
    int       burst_left;
    event     hold_go;
    bit       holding = 1'b0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [31:0] lfsr_next(input logic [31:0] s);
        return {1'b0, s[31:1]} ^ (s[0] ? LFSR_MASK : 32'h0);
    endfunction

    function automatic outcome_t apply_command(input mode_t mode, input logic [7:0] card,
                                               input logic [6:0] pos);
        outcome_t             r;
        logic [CARD_BITS-1:0] work [CAPACITY];
        logic [CARD_BITS-1:0] t;
        int                   j;
        r = '0;
        case (mode)
            MODE_PUSH: begin
                if (held >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (int k = held; k > 0; k--) deck[k] = deck[k-1];
                    deck[0] = card;
                    held++;
                end
            end
            MODE_REMOVE: begin
                if (pos >= held) begin
                    r.card   = empty_code;
                    r.status = ST_BAD;
                end else begin
                    r.card = deck[pos];
                    for (int k = pos; k + 1 < held; k++) deck[k] = deck[k+1];
                    held--;
                end
            end
            MODE_SHUFFLE: begin
                if (held >= 2) begin
                    for (int k = 0; k < held; k++) work[k] = deck[k];
                    for (int i = held - 1; i > 0; i--) begin
                        lfsr    = lfsr_next(lfsr);
                        j       = lfsr % (i + 1);
                        t       = work[i];
                        work[i] = work[j];
                        work[j] = t;
                    end
                    for (int k = 0; k < held; k++) deck[k] = work[held-1-k];
                end
            end
            default: ;
        endcase
        r.count = held[7:0];
        return r;
    endfunction

    task automatic write_reg(input logic addr, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (addr == CFG_EMPTY_CARD) empty_code = value[7:0];
        else lfsr = (value == 0) ? 32'h1 : value;
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic send(input cmd_row_t row);
        outcome_t r;
        if (burst_left == 0) begin
            if (s_axis_tvalid) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, row.pos, row.card, row.mode};
        do @(posedge aclk); while (!s_axis_tready);
        r = apply_command(row.mode, row.card, row.pos);
        pending_q.push_back(row.typed ? row.want : r);
    endtask

    function automatic cmd_row_t rand_cmd(input int push_pct);
        cmd_row_t c;
        int       roll;
        roll   = $urandom_range(0, 99);
        c.card = 8'($urandom_range(0, 255));
        c.pos  = 7'($urandom_range(0, 127));
        c.typed = 1'b0;
        c.want  = '0;
        if (roll < push_pct) c.mode = MODE_PUSH;
        else if (roll < 93) begin
            c.mode = MODE_REMOVE;
            if (held > 0 && $urandom_range(0, 9) != 0) c.pos = 7'($urandom_range(0, held - 1));
        end else if (roll < 97) c.mode = MODE_SHUFFLE;
        else c.mode = MODE_UNUSED;
        return c;
    endfunction

    // result side: checks and stall pattern
    always @(posedge aclk) begin
        outcome_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[7:0], m_axis_tdata[9:8], m_axis_tdata[17:10]};
            if (pending_q.size() == 0) begin
                report("unexpected result", got, 0);
            end else begin
                want = pending_q.pop_front();
                if (got.card !== want.card) report("card_out", got.card, want.card);
                if (got.status !== want.status) report("status", got.status, want.status);
                if (got.count !== want.count) report("card_count", got.count, want.count);
            end
        end
    end

    // long receiver hold, counted in cycles
    always begin
        @(hold_go);
        holding <= 1'b1;
        repeat (400) @(posedge aclk);
        holding <= 1'b0;
    end

    always @(posedge aclk) begin
        if (holding) begin
            m_axis_tready <= 1'b0;
        end else begin
            case (($time / 20000) % 3)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 0);
                default: m_axis_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    initial begin
        #100_000_000;
        $display("Test completed with failures");
        $finish;
    end

    cmd_row_t directed[$];

    initial begin
        cmd_row_t c;
        errors = 0;
        burst_left = 0;
        held = 0;
        lfsr = 32'h1;
        empty_code = '0;
        for (int k = 0; k < CAPACITY; k++) deck[k] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // mode, card, pos, typed, {card_out, status, count}
        directed = '{
            '{MODE_REMOVE,  8'd0,   7'd0,   1'b1, '{8'd0,   ST_BAD, 8'd0}},
            '{MODE_SHUFFLE, 8'd0,   7'd0,   1'b1, '{8'd0,   ST_OK,  8'd0}},
            '{MODE_UNUSED,  8'd255, 7'd127, 1'b1, '{8'd0,   ST_OK,  8'd0}},
            '{MODE_PUSH,    8'd255, 7'd127, 1'b1, '{8'd0,   ST_OK,  8'd1}},
            '{MODE_SHUFFLE, 8'd0,   7'd0,   1'b1, '{8'd0,   ST_OK,  8'd1}},
            '{MODE_PUSH,    8'd0,   7'd0,   1'b1, '{8'd0,   ST_OK,  8'd2}},
            '{MODE_REMOVE,  8'd0,   7'd127, 1'b1, '{8'd0,   ST_BAD, 8'd2}},
            '{MODE_REMOVE,  8'd0,   7'd2,   1'b1, '{8'd0,   ST_BAD, 8'd2}},
            '{MODE_REMOVE,  8'd0,   7'd1,   1'b1, '{8'd255, ST_OK,  8'd1}},
            '{MODE_PUSH,    8'hA5,  7'd0,   1'b0, '0},
            '{MODE_PUSH,    8'h5A,  7'd0,   1'b0, '0},
            '{MODE_SHUFFLE, 8'd0,   7'd0,   1'b0, '0},
            '{MODE_REMOVE,  8'd0,   7'd1,   1'b0, '0},
            '{MODE_REMOVE,  8'd0,   7'd0,   1'b0, '0},
            '{MODE_REMOVE,  8'd0,   7'd0,   1'b0, '0},
            '{MODE_REMOVE,  8'd0,   7'd0,   1'b1, '{8'd0,   ST_BAD, 8'd0}}
        };
        foreach (directed[i]) send(directed[i]);
        drain();

        write_reg(CFG_EMPTY_CARD, 32'hFF);
        write_reg(CFG_SEED, 32'h0);
        // fill to capacity, then overflow, full shuffle and far removal
        for (int i = 0; i < CAPACITY; i++) begin
            c = rand_cmd(100);
            send(c);
        end
        c = '{MODE_PUSH, 8'h33, 7'd0, 1'b1, '{8'd0, ST_FULL, 8'd128}};
        send(c);
        c = '{MODE_SHUFFLE, 8'd0, 7'd0, 1'b0, '0};
        send(c);
        c = '{MODE_REMOVE, 8'd0, 7'd127, 1'b0, '0};
        send(c);
        c = '{MODE_REMOVE, 8'd0, 7'd127, 1'b1, '{8'hFF, ST_BAD, 8'd127}};
        send(c);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_EMPTY_CARD, 32'h0);
                    write_reg(CFG_SEED, 32'hFFFF_FFFF);
                end
                1: begin
                    write_reg(CFG_EMPTY_CARD, $urandom_range(0, 255));
                    write_reg(CFG_SEED, 32'h1);
                end
                default: begin
                    write_reg(CFG_EMPTY_CARD, $urandom_range(0, 255));
                    write_reg(CFG_SEED, $urandom);
                end
            endcase
            for (int n = 0; n < 400; n++) begin
                if (ph == 1 && n == 50) -> hold_go;
                c = rand_cmd(ph == 2 ? 70 : 48);
                send(c);
            end
            drain();
        end

        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
